/* rtl/segalloc_pkg.sv */
// ----------------------------------------------------------------------------
// Segment allocator package
// Shared constants, register indexes and status codes of the segment
// allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package segalloc_pkg;

  localparam int MaxSegments = 64;
  localparam int SizeBits    = 21;
  localparam int IdBits      = 16;

  localparam int MemTotalRst = 1048576;
  localparam int MinBlockRst = 1;

  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_BLOCK  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MEM_TOTAL  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_NO_ID   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

endpackage

/* rtl/segalloc_alu.sv */
// ----------------------------------------------------------------------------
// Segment allocator adder
// Shared add/subtract unit; on subtraction the carry is set when a >= b.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segalloc_alu #(
  parameter int WIDTH = 21
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o,
  output logic             carry_o
);

  logic [WIDTH:0] full;

  assign full    = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{WIDTH{1'b0}}, sub_i};
  assign sum_o   = full[WIDTH-1:0];
  assign carry_o = full[WIDTH];

endmodule

/* rtl/segment_allocator_fit_coalesce_top.sv */
// ----------------------------------------------------------------------------
// Segment allocator with first/best fit and coalescing
// Keeps an address-ordered segment table in a memory and serves allocate
// and free requests with one shared adder under a small sequencer.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   req_type, req_size, owner_id
//   out      output     out_valid_o / out_ready_i status, granted_size
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A request walks the table one entry per cycle through the memory read
// port (all entries for best fit), then moves one entry per cycle when a
// split or merge shifts the table, and then writes its updated entries.
// After reset and after each memory_total write the block rebuilds the
// table before it takes a request.
// A result that waits at the output does not stop the next transfer in;
// the block only holds its result stage when the output is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_allocator_fit_coalesce_top
  import segalloc_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegments,
  parameter int SIZE_BITS    = SizeBits,
  parameter int ID_BITS      = IdBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [SIZE_BITS-1:0]  req_size_i,
  input  logic [ID_BITS-1:0]    owner_id_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [SIZE_BITS-1:0]  granted_size_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [SIZE_BITS-1:0]  cfg_data_i
);

  localparam int ADDR_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int ENT_W  = 1 + ID_BITS + SIZE_BITS;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_SHIFT    = 4'd4;
  localparam logic [3:0] S_WR_REST  = 4'd5;
  localparam logic [3:0] S_WR_OWN   = 4'd6;
  localparam logic [3:0] S_RD_NEXT  = 4'd7;
  localparam logic [3:0] S_RD_PREV  = 4'd8;
  localparam logic [3:0] S_ADD_NEXT = 4'd9;
  localparam logic [3:0] S_ADD_PREV = 4'd10;
  localparam logic [3:0] S_WR_FREE  = 4'd11;
  localparam logic [3:0] S_RESP     = 4'd12;

  logic [3:0]           state_q, state_d;
  logic                 fit_q, fit_d;
  logic [SIZE_BITS-1:0] min_block_q, min_block_d;
  logic [SIZE_BITS-1:0] mem_total_q, mem_total_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 free_q, free_d;
  logic [SIZE_BITS-1:0] need_q, need_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 pend_q, pend_d;
  logic [CNT_W-1:0]     pend_idx_q, pend_idx_d;
  logic                 found_q, found_d;
  logic [CNT_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] pick_size_q, pick_size_d;
  logic [SIZE_BITS-1:0] rest_q, rest_d;
  logic                 split_q, split_d;
  logic                 shift_up_q, shift_up_d;
  logic [1:0]           shk_q, shk_d;
  logic                 nfree_q, nfree_d;
  logic [SIZE_BITS-1:0] nsize_q, nsize_d;
  logic                 pfree_q, pfree_d;
  logic [SIZE_BITS-1:0] psize_q, psize_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  status_e              res_status_q, res_status_d;
  logic [SIZE_BITS-1:0] res_size_q, res_size_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [SIZE_BITS-1:0] out_size_q, out_size_d;

  logic [ENT_W-1:0]     seg_mem [MAX_SEGMENTS];
  logic [ENT_W-1:0]     rdata_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [ENT_W-1:0]     mem_wdata;

  logic                 r_free;
  logic [ID_BITS-1:0]   r_id;
  logic [SIZE_BITS-1:0] r_size;

  logic [SIZE_BITS-1:0] alu_a, alu_b, alu_sum;
  logic                 alu_sub, alu_carry;

  assign r_free = rdata_q[ENT_W-1];
  assign r_id   = rdata_q[SIZE_BITS +: ID_BITS];
  assign r_size = rdata_q[SIZE_BITS-1:0];

  segalloc_alu #(
    .WIDTH(SIZE_BITS)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= seg_mem[mem_raddr];
  end

  always_comb begin
    logic             issue;
    logic             hit;
    logic             take;
    logic             stop;
    logic [CNT_W-1:0] dest;
    logic [1:0]       k;

    state_d      = state_q;
    fit_d        = fit_q;
    min_block_d  = min_block_q;
    mem_total_d  = mem_total_q;
    count_d      = count_q;
    free_d       = free_q;
    need_d       = need_q;
    id_d         = id_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    found_d      = found_q;
    pick_d       = pick_q;
    pick_size_d  = pick_size_q;
    rest_d       = rest_q;
    split_d      = split_q;
    shift_up_d   = shift_up_q;
    shk_d        = shk_q;
    nfree_d      = nfree_q;
    nsize_d      = nsize_q;
    pfree_d      = pfree_q;
    psize_d      = psize_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    res_size_d   = res_size_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_size_d   = out_size_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = idx_q[ADDR_W-1:0];
    alu_a     = r_size;
    alu_b     = need_q;
    alu_sub   = 1'b1;

    issue = 1'b0;
    hit   = 1'b0;
    take  = 1'b0;
    stop  = 1'b0;
    dest  = pick_q;
    k     = 2'd0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {1'b1, {ID_BITS{1'b0}}, mem_total_q};
        count_d   = CNT_ONE;
        state_d   = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid_i) begin
          free_d  = req_type_i;
          need_d  = (req_size_i < min_block_q) ? min_block_q : req_size_i;
          id_d    = owner_id_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        issue = idx_q < count_q;
        if (free_q == REQ_FREE) begin
          hit  = pend_q && !r_free && (r_id == id_q);
          take = hit && !found_q;
          stop = take;
        end else begin
          hit  = pend_q && r_free && alu_carry;
          take = hit && (!found_q || ((fit_q == FIT_BEST) && (r_size < pick_size_q)));
          stop = take && (fit_q == FIT_FIRST);
        end
        if (take) begin
          found_d     = 1'b1;
          pick_d      = pend_idx_q;
          pick_size_d = r_size;
        end
        pend_d     = issue;
        pend_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + CNT_ONE;
        end
        if (stop || (!issue && !pend_q)) begin
          pend_d = 1'b0;
          if (free_q == REQ_FREE) begin
            if (found_d) begin
              state_d = S_RD_NEXT;
            end else begin
              res_status_d = ST_NO_ID;
              res_size_d   = '0;
              state_d      = S_RESP;
            end
          end else begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        alu_a = pick_size_q;
        alu_b = need_q;
        if (!found_q) begin
          res_status_d = ST_NO_FIT;
          res_size_d   = '0;
          state_d      = S_RESP;
        end else if (alu_sum == '0) begin
          split_d = 1'b0;
          state_d = S_WR_OWN;
        end else if (count_q >= CNT_MAX) begin
          res_status_d = ST_FULL;
          res_size_d   = '0;
          state_d      = S_RESP;
        end else begin
          split_d    = 1'b1;
          rest_d     = alu_sum;
          idx_d      = count_q - CNT_ONE;
          pend_d     = 1'b0;
          shift_up_d = 1'b1;
          state_d    = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (shift_up_q) begin
          issue     = idx_q > pick_q;
          mem_waddr = ADDR_W'(pend_idx_q + CNT_ONE);
        end else begin
          issue     = idx_q < count_q;
          mem_waddr = ADDR_W'(pend_idx_q - CNT_W'(shk_q));
        end
        mem_we     = pend_q;
        mem_wdata  = rdata_q;
        pend_d     = issue;
        pend_idx_d = idx_q;
        if (issue) begin
          idx_d = shift_up_q ? (idx_q - CNT_ONE) : (idx_q + CNT_ONE);
        end
        if (!issue && !pend_q) begin
          if (shift_up_q) begin
            state_d = S_WR_REST;
          end else begin
            count_d      = count_q - CNT_W'(shk_q);
            res_status_d = ST_OK;
            res_size_d   = '0;
            state_d      = S_RESP;
          end
        end
      end

      S_WR_REST: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(pick_q + CNT_ONE);
        mem_wdata = {1'b1, {ID_BITS{1'b0}}, rest_q};
        state_d   = S_WR_OWN;
      end

      S_WR_OWN: begin
        mem_we    = 1'b1;
        mem_waddr = pick_q[ADDR_W-1:0];
        mem_wdata = {1'b0, id_q, need_q};
        if (split_q) begin
          count_d = count_q + CNT_ONE;
        end
        res_status_d = ST_OK;
        res_size_d   = need_q;
        state_d      = S_RESP;
      end

      S_RD_NEXT: begin
        mem_raddr = ADDR_W'(pick_q + CNT_ONE);
        state_d   = S_RD_PREV;
      end

      S_RD_PREV: begin
        nfree_d   = ((pick_q + CNT_ONE) < count_q) && r_free;
        nsize_d   = r_size;
        mem_raddr = ADDR_W'(pick_q - CNT_ONE);
        state_d   = S_ADD_NEXT;
      end

      S_ADD_NEXT: begin
        pfree_d = (pick_q != '0) && r_free;
        psize_d = r_size;
        alu_a   = pick_size_q;
        alu_b   = nfree_q ? nsize_q : '0;
        alu_sub = 1'b0;
        acc_d   = alu_sum;
        state_d = S_ADD_PREV;
      end

      S_ADD_PREV: begin
        alu_a   = acc_q;
        alu_b   = pfree_q ? psize_q : '0;
        alu_sub = 1'b0;
        acc_d   = alu_sum;
        state_d = S_WR_FREE;
      end

      S_WR_FREE: begin
        dest      = pfree_q ? (pick_q - CNT_ONE) : pick_q;
        k         = {1'b0, nfree_q} + {1'b0, pfree_q};
        mem_we    = 1'b1;
        mem_waddr = dest[ADDR_W-1:0];
        mem_wdata = {1'b1, {ID_BITS{1'b0}}, acc_q};
        if (k == 2'd0) begin
          res_status_d = ST_OK;
          res_size_d   = '0;
          state_d      = S_RESP;
        end else begin
          shk_d      = k;
          idx_d      = dest + CNT_W'(k) + CNT_ONE;
          pend_d     = 1'b0;
          shift_up_d = 1'b0;
          state_d    = S_SHIFT;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_size_d   = res_size_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_INIT;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIT_POLICY: fit_d = cfg_data_i[0];
        CFG_MIN_BLOCK:  min_block_d = cfg_data_i;
        CFG_MEM_TOTAL: begin
          mem_total_d = cfg_data_i;
          state_d     = S_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      fit_q        <= FIT_FIRST;
      min_block_q  <= SIZE_BITS'(MinBlockRst);
      mem_total_q  <= SIZE_BITS'(MemTotalRst);
      count_q      <= CNT_ONE;
      free_q       <= REQ_ALLOC;
      need_q       <= '0;
      id_q         <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      found_q      <= 1'b0;
      pick_q       <= '0;
      pick_size_q  <= '0;
      rest_q       <= '0;
      split_q      <= 1'b0;
      shift_up_q   <= 1'b0;
      shk_q        <= 2'd0;
      nfree_q      <= 1'b0;
      nsize_q      <= '0;
      pfree_q      <= 1'b0;
      psize_q      <= '0;
      acc_q        <= '0;
      res_status_q <= ST_OK;
      res_size_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_size_q   <= '0;
    end else begin
      state_q      <= state_d;
      fit_q        <= fit_d;
      min_block_q  <= min_block_d;
      mem_total_q  <= mem_total_d;
      count_q      <= count_d;
      free_q       <= free_d;
      need_q       <= need_d;
      id_q         <= id_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      pend_idx_q   <= pend_idx_d;
      found_q      <= found_d;
      pick_q       <= pick_d;
      pick_size_q  <= pick_size_d;
      rest_q       <= rest_d;
      split_q      <= split_d;
      shift_up_q   <= shift_up_d;
      shk_q        <= shk_d;
      nfree_q      <= nfree_d;
      nsize_q      <= nsize_d;
      pfree_q      <= pfree_d;
      psize_q      <= psize_d;
      acc_q        <= acc_d;
      res_status_q <= res_status_d;
      res_size_q   <= res_size_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_size_q   <= out_size_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_size_o = out_size_q;

endmodule

/* rtl/segalloc_checker.sv */
// ----------------------------------------------------------------------------
// Segment allocator checker
// Port-level assertions on the segment allocator, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segalloc_props
  import segalloc_pkg::*;
#(
  parameter int SIZE_BITS = SizeBits
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [1:0]           status_o,
  input logic [SIZE_BITS-1:0] granted_size_o
);

  // A result that is not taken stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(granted_size_o))
    else $error("output result changed while stalled");

  // Only a successful allocation carries a nonzero size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> granted_size_o == '0)
    else $error("failed request reports a granted size");

  // The block works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // A new result only appears at the end of a request's work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the block was idle");

endmodule

bind segment_allocator_fit_coalesce_top segalloc_props #(
  .SIZE_BITS(SIZE_BITS)
) u_segalloc_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .granted_size_o(granted_size_o)
);
